// ----- rtl/core/stks_pkg.sv -----
// ---------------------------------------------------------------------------
// stks_pkg - shared types and constants for the sorted table key search
// Holds the table entry layout, result codes and the sequencer states.
// ---------------------------------------------------------------------------
package stks_pkg;

    // Default table depth
    localparam int DEPTH_DEFAULT = 1024;

    // Fixed payload widths
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 10;
    localparam int OPOS_W   = 11;

    // Command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_APPENDED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    // Position reported when nothing matched
    localparam logic [OPOS_W-1:0] POS_NONE = '1;

    // One table entry: value and its arrival position
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } entry_t;

    // Result of the shared comparator
    typedef struct packed {
        logic lt;
        logic gt;
    } cmp_res_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SORT_NEXT,
        ST_SORT_LOAD,
        ST_SORT_PROBE,
        ST_SORT_CMP,
        ST_SRCH_INIT,
        ST_SRCH_PROBE,
        ST_SRCH_CMP,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/stks_cmd_if.sv -----
// ---------------------------------------------------------------------------
// stks_cmd_if - command channel
// Carries one append or search command per beat.
// ---------------------------------------------------------------------------
interface stks_cmd_if;

    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [stks_pkg::VALUE_W-1:0]    value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);

endinterface

// ----- rtl/core/stks_res_if.sv -----
// ---------------------------------------------------------------------------
// stks_res_if - result channel
// Carries one status and matched arrival position per beat.
// ---------------------------------------------------------------------------
interface stks_res_if;

    logic                                   valid;
    logic                                   ready;
    logic [stks_pkg::STATUS_W-1:0]          status;
    logic signed [stks_pkg::OPOS_W-1:0]     original_position;

    modport source (output valid, output status, output original_position, input ready);
    modport sink   (input valid, input status, input original_position, output ready);

endinterface

// ----- rtl/core/stks_mem.sv -----
// ---------------------------------------------------------------------------
// stks_mem - table storage
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module stks_mem #(
    parameter int DEPTH = stks_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  stks_pkg::entry_t            wdata,
    input  logic                        re,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output stks_pkg::entry_t            rdata
);

    stks_pkg::entry_t mem [DEPTH];
    stks_pkg::entry_t rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data valid the cycle after the request
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/stks_cmp.sv -----
// ---------------------------------------------------------------------------
// stks_cmp - shared signed comparator
// Orders two signed values; used by both the sort and the search steps.
// ---------------------------------------------------------------------------
module stks_cmp (
    input  logic signed [stks_pkg::VALUE_W-1:0] a,
    input  logic signed [stks_pkg::VALUE_W-1:0] b,
    output stks_pkg::cmp_res_t                  res
);

    // Signed order of a against b
    always_comb
    begin
        res.lt = (a < b);
        res.gt = (a > b);
    end

endmodule

// ----- rtl/core/sorted_table_key_search.sv -----
// Append: the command beat writes the tail entry, then the emit step hands over the result.
// Search: each binary-search probe reads the table and then compares, and a miss ends once the range empties;
// at most clog2(count+1) probes through the table read port and the shared comparator.
// The first search after appends first inserts each new entry, shifting each greater neighbor
// up one slot, and then closes the pass. One command is in work at a time.
// Reset empties the table (count and sort mark); the memory itself is not cleared.
// ---------------------------------------------------------------------------
// sorted_table_key_search - top level
// Sequencer over one table memory and one comparator: appends, lazy stable
// insertion sort of new entries, and binary search for a key.
// ---------------------------------------------------------------------------
module sorted_table_key_search #(
    parameter int DEPTH = stks_pkg::DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    stks_cmd_if.sink        cmd_ch,
    stks_res_if.source      res_ch
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    stks_pkg::state_t                       state_reg, state_next;
    logic [CW-1:0]                          count_reg, count_next;
    logic [CW-1:0]                          sorted_reg, sorted_next;
    logic [CW-1:0]                          i_reg, i_next;
    logic [CW-1:0]                          j_reg, j_next;
    logic [CW-1:0]                          mid_reg, mid_next;
    logic signed [SW-1:0]                   low_reg, low_next;
    logic signed [SW-1:0]                   high_reg, high_next;
    stks_pkg::entry_t                       hold_reg, hold_next;
    logic signed [stks_pkg::VALUE_W-1:0]    key_reg, key_next;
    logic [stks_pkg::STATUS_W-1:0]          res_status_reg, res_status_next;
    logic [stks_pkg::OPOS_W-1:0]            res_pos_reg, res_pos_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [stks_pkg::STATUS_W-1:0]          out_status_reg, out_status_next;
    logic [stks_pkg::OPOS_W-1:0]            out_pos_reg, out_pos_next;

    logic                                   mem_we;
    logic [AW-1:0]                          mem_waddr;
    stks_pkg::entry_t                       mem_wdata;
    logic                                   mem_re;
    logic [AW-1:0]                          mem_raddr;
    stks_pkg::entry_t                       mem_rdata;

    logic signed [stks_pkg::VALUE_W-1:0]    cmp_a;
    logic signed [stks_pkg::VALUE_W-1:0]    cmp_b;
    stks_pkg::cmp_res_t                     cmp_res;

    logic                                   cmd_beat;
    logic                                   out_free;
    logic [CW-1:0]                          j_dec;
    logic [CW:0]                            mid_sum;

    stks_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    stks_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    assign cmd_ch.ready             = (state_reg == stks_pkg::ST_IDLE);
    assign cmd_beat                 = cmd_ch.valid && cmd_ch.ready;
    assign out_free                 = !out_valid_reg || res_ch.ready;
    assign res_ch.valid             = out_valid_reg;
    assign res_ch.status            = out_status_reg;
    assign res_ch.original_position = out_pos_reg;

    assign j_dec   = j_reg - CW'(1);
    assign mid_sum = {1'b0, low_reg[CW-1:0]} + {1'b0, high_reg[CW-1:0]};

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stks_pkg::ST_IDLE;
            count_reg     <= '0;
            sorted_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        mid_reg        <= mid_next;
        low_reg        <= low_next;
        high_reg       <= high_next;
        hold_reg       <= hold_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
    end

    // Next state, memory and comparator control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        sorted_next     = sorted_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        mid_next        = mid_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        hold_next       = hold_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[AW-1:0];
        mem_wdata       = hold_reg;
        mem_re          = 1'b0;
        mem_raddr       = mid_reg[AW-1:0];
        cmp_a           = key_reg;
        cmp_b           = mem_rdata.value;

        // Drain the output register
        if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            stks_pkg::ST_IDLE:
            begin
                if (cmd_beat)
                begin
                    key_next = cmd_ch.value;
                    res_pos_next = stks_pkg::POS_NONE;
                    if (cmd_ch.command == stks_pkg::CMD_APPEND)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            res_status_next = stks_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            // Store at the tail, tagged with its arrival position
                            mem_we             = 1'b1;
                            mem_waddr          = count_reg[AW-1:0];
                            mem_wdata.value    = cmd_ch.value;
                            mem_wdata.position = stks_pkg::POS_W'(count_reg);
                            count_next         = count_reg + CW'(1);
                            res_status_next    = stks_pkg::STATUS_APPENDED;
                        end
                        state_next = stks_pkg::ST_EMIT;
                    end
                    else if (sorted_reg != count_reg)
                    begin
                        // Entry zero alone is always in order
                        i_next     = (sorted_reg == '0) ? CW'(1) : sorted_reg;
                        state_next = stks_pkg::ST_SORT_NEXT;
                    end
                    else
                    begin
                        state_next = stks_pkg::ST_SRCH_INIT;
                    end
                end
            end

            stks_pkg::ST_SORT_NEXT:
            begin
                if (i_reg >= count_reg)
                begin
                    sorted_next = count_reg;
                    state_next  = stks_pkg::ST_SRCH_INIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = i_reg[AW-1:0];
                    state_next = stks_pkg::ST_SORT_LOAD;
                end
            end

            stks_pkg::ST_SORT_LOAD:
            begin
                // Lift the entry out and open a hole at its slot
                hold_next  = mem_rdata;
                j_next     = i_reg;
                state_next = stks_pkg::ST_SORT_PROBE;
            end

            stks_pkg::ST_SORT_PROBE:
            begin
                if (j_reg == '0)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = j_reg[AW-1:0];
                    mem_wdata  = hold_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = stks_pkg::ST_SORT_NEXT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = j_dec[AW-1:0];
                    state_next = stks_pkg::ST_SORT_CMP;
                end
            end

            stks_pkg::ST_SORT_CMP:
            begin
                // Shift a strictly greater neighbor up; equal ones stay ahead
                cmp_a     = mem_rdata.value;
                cmp_b     = hold_reg.value;
                mem_we    = 1'b1;
                mem_waddr = j_reg[AW-1:0];
                if (cmp_res.gt)
                begin
                    mem_wdata  = mem_rdata;
                    j_next     = j_dec;
                    state_next = stks_pkg::ST_SORT_PROBE;
                end
                else
                begin
                    mem_wdata  = hold_reg;
                    i_next     = i_reg + CW'(1);
                    state_next = stks_pkg::ST_SORT_NEXT;
                end
            end

            stks_pkg::ST_SRCH_INIT:
            begin
                low_next   = '0;
                high_next  = $signed({1'b0, count_reg}) - $signed(SW'(1));
                state_next = stks_pkg::ST_SRCH_PROBE;
            end

            stks_pkg::ST_SRCH_PROBE:
            begin
                if (low_reg > high_reg)
                begin
                    res_status_next = stks_pkg::STATUS_NOT_FOUND;
                    state_next      = stks_pkg::ST_EMIT;
                end
                else
                begin
                    mid_next   = mid_sum[CW:1];
                    mem_re     = 1'b1;
                    mem_raddr  = mid_sum[AW:1];
                    state_next = stks_pkg::ST_SRCH_CMP;
                end
            end

            stks_pkg::ST_SRCH_CMP:
            begin
                cmp_a = key_reg;
                cmp_b = mem_rdata.value;
                if (cmp_res.lt)
                begin
                    high_next  = $signed({1'b0, mid_reg}) - $signed(SW'(1));
                    state_next = stks_pkg::ST_SRCH_PROBE;
                end
                else if (cmp_res.gt)
                begin
                    low_next   = $signed({1'b0, mid_reg}) + $signed(SW'(1));
                    state_next = stks_pkg::ST_SRCH_PROBE;
                end
                else
                begin
                    res_status_next = stks_pkg::STATUS_FOUND;
                    res_pos_next    = stks_pkg::OPOS_W'(mem_rdata.position);
                    state_next      = stks_pkg::ST_EMIT;
                end
            end

            stks_pkg::ST_EMIT:
            begin
                // Hand the result over once the output register is free
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    state_next      = stks_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = stks_pkg::ST_IDLE;
            end
        endcase
    end

    // The sorted prefix never runs past the filled part of the table
    a_sorted_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_reg <= count_reg)
        else $error("sorted prefix longer than table");

    // The fill count never exceeds the table depth
    a_count_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("table count beyond depth");

    // An accepted append into a table with room grows it by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_beat && cmd_ch.command == stks_pkg::CMD_APPEND && count_reg != CW'(DEPTH))
        |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("append did not grow table");

    // A new result appears only out of the emit step
    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !res_ch.ready))
        |-> $past(state_reg == stks_pkg::ST_EMIT))
        else $error("result beat without emit step");

    // A result never reports a match without the found status
    a_pos_none_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stks_pkg::ST_EMIT && res_status_reg != stks_pkg::STATUS_FOUND)
        |-> (res_pos_reg == stks_pkg::POS_NONE))
        else $error("position reported without a match");

endmodule
